// ===== rtl/lda_pkg.sv =====
// Shared types and constants for the lattice distance argsort block.
`default_nettype none
package lda_pkg;
	localparam int LatW = 21;
	localparam int RowW = 63;
	localparam int FracW = 32;
	localparam int TypeW = 8;
	localparam int DistW = 48;
	localparam int KeyW = TypeW + DistW;
	localparam int OffW = 25;
	localparam int ProdW = LatW + OffW;
	localparam int CompW = ProdW + 2;
	localparam int MagW = 31;
	localparam int SqW = 2 * MagW;

	localparam logic [1:0] RegRow0 = 2'd0;
	localparam logic [1:0] RegRow1 = 2'd1;
	localparam logic [1:0] RegRow2 = 2'd2;
	localparam logic [1:0] RegTypes = 2'd3;

	typedef logic [KeyW-1:0] key_t;

	typedef struct packed {
		logic [RowW-1:0] row0;
		logic [RowW-1:0] row1;
		logic [RowW-1:0] row2;
		logic            use_types;
	} cfg_t;

	function automatic logic signed [OffW-1:0] frac_offset(input logic [FracW-1:0] raw);
		logic [23:0] f;
		f = raw[23:0];
		if (f > 24'h800000)
			return $signed({1'b0, f}) - 25'sh1000000;
		else if (f == 24'h800000)
			return raw[FracW-1] ? 25'sh0800000 : -25'sh0800000;
		else
			return $signed({1'b0, f});
	endfunction
endpackage
`default_nettype wire

// ===== rtl/lda_dist.sv =====
// Pipelined lattice distance front end: offsets, products, rounding, squares and sum.
`default_nettype none
module lda_dist (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire lda_pkg::cfg_t   cfg,
	input  wire [7:0]            atom_type,
	input  wire [31:0]           frac_x,
	input  wire [31:0]           frac_y,
	input  wire [31:0]           frac_z,
	input  wire                  in_last,
	output logic                 out_valid,
	output lda_pkg::key_t        out_key,
	output logic                 out_last
);
	import lda_pkg::*;

	logic [4:0] valid_q;
	logic [4:0] last_q;
	logic [TypeW-1:0] type_s1, type_s2, type_s3, type_s4, type_s5;
	logic signed [OffW-1:0] off_s1 [3];
	logic [RowW-1:0] row_s1 [3];
	logic signed [ProdW-1:0] prod_s2 [3][3];
	logic [MagW-1:0] mag_s3 [3];
	logic [SqW-1:0] sq_s4 [3];
	logic [DistW-1:0] dist_s5;
	logic signed [CompW-1:0] comp [3];
	logic [CompW-1:0] absv [3];
	logic [CompW-1:0] rnd [3];
	logic [SqW+1:0] sum;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			comp[i] = CompW'(prod_s2[i][0]) + CompW'(prod_s2[i][1]) + CompW'(prod_s2[i][2]);
			absv[i] = comp[i][CompW-1] ? CompW'(-comp[i]) : CompW'(comp[i]);
			rnd[i] = (absv[i] + CompW'(20'h20000)) >> 18;
		end
		sum = (SqW+2)'(sq_s4[0]) + (SqW+2)'(sq_s4[1]) + (SqW+2)'(sq_s4[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			last_q <= '0;
		end else begin
			valid_q <= {valid_q[3:0], in_valid};
			last_q <= {last_q[3:0], in_last};
		end
	end

	always_ff @(posedge clk) begin
		type_s1 <= cfg.use_types ? atom_type : '0;
		off_s1[0] <= frac_offset(frac_x);
		off_s1[1] <= frac_offset(frac_y);
		off_s1[2] <= frac_offset(frac_z);
		row_s1[0] <= cfg.row0;
		row_s1[1] <= cfg.row1;
		row_s1[2] <= cfg.row2;
		type_s2 <= type_s1;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				prod_s2[i][j] <= $signed(row_s1[i][LatW*j +: LatW]) * off_s1[j];
		type_s3 <= type_s2;
		for (int i = 0; i < 3; i++)
			mag_s3[i] <= MagW'(rnd[i]);
		type_s4 <= type_s3;
		for (int i = 0; i < 3; i++)
			sq_s4[i] <= mag_s3[i] * mag_s3[i];
		type_s5 <= type_s4;
		dist_s5 <= (sum > (SqW+2)'({DistW{1'b1}})) ? {DistW{1'b1}} : DistW'(sum);
	end

	assign out_valid = valid_q[4];
	assign out_last = last_q[4];
	assign out_key = {type_s5, dist_s5};
endmodule
`default_nettype wire

// ===== rtl/lda_cell.sv =====
// One insertion cell of the sorting chain, holding a key and its load index.
`default_nettype none
module lda_cell #(
	parameter int IdxW = 6
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                ins,
	input  wire                shift,
	input  wire lda_pkg::key_t new_key,
	input  wire [IdxW-1:0]     new_idx,
	input  wire                prev_full,
	input  wire                prev_gt,
	input  wire lda_pkg::key_t prev_key,
	input  wire [IdxW-1:0]     prev_idx,
	input  wire lda_pkg::key_t next_key,
	input  wire [IdxW-1:0]     next_idx,
	input  wire                next_full,
	output logic               full,
	output logic               gt,
	output lda_pkg::key_t      key,
	output logic [IdxW-1:0]    idx
);
	import lda_pkg::*;

	logic full_q;
	key_t key_q;
	logic [IdxW-1:0] idx_q;

	assign gt = full_q && (key_q > new_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (shift) begin
			full_q <= next_full;
		end else if (ins && (gt || !full_q) && prev_full) begin
			full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q <= next_key;
			idx_q <= next_idx;
		end else if (ins && (gt || !full_q)) begin
			if (prev_gt) begin
				key_q <= prev_key;
				idx_q <= prev_idx;
			end else if (prev_full) begin
				key_q <= new_key;
				idx_q <= new_idx;
			end
		end
	end

	assign full = full_q;
	assign key = key_q;
	assign idx = idx_q;
endmodule
`default_nettype wire

// ===== rtl/lattice_distance_argsort.sv =====
// Top level of the lattice distance argsort block.
// An atom can enter each cycle in Load; its key passes the offset, product, rounding,
// square and sum registers to the insertion chain. After the last atom, results leave
// the chain head one per cycle while out_ready is high; Drain and Emit refuse atoms.
// The lattice rows reset to zero, the type mode to one, and the chain to empty.
`default_nettype none
module lattice_distance_argsort #(
	parameter int MAX_ATOMS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire [1:0]   cfg_index,
	input  wire [62:0]  cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire [7:0]   atom_type,
	input  wire [31:0]  frac_x,
	input  wire [31:0]  frac_y,
	input  wire [31:0]  frac_z,
	input  wire         last,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [5:0]  source_index,
	output logic [7:0]  type_out,
	output logic [47:0] distance_sq,
	output logic        last_out
);
	import lda_pkg::*;

	localparam int IdxW = $clog2(MAX_ATOMS);
	localparam int CntW = $clog2(MAX_ATOMS + 1);

	typedef enum logic [1:0] {Load, Drain, Emit} state_t;

	cfg_t cfg_q;
	state_t state_q;
	logic [CntW-1:0] ins_cnt_q;
	logic [CntW-1:0] emit_cnt_q;
	logic [IdxW-1:0] next_idx_q;
	logic acc;
	logic d_valid, d_last;
	key_t d_key;
	logic take, ins, shift;
	logic full [MAX_ATOMS+1];
	logic gt [MAX_ATOMS+1];
	key_t key [MAX_ATOMS+2];
	logic [IdxW-1:0] idx [MAX_ATOMS+2];

	assign in_ready = (state_q == Load);
	assign acc = in_valid && in_ready;
	assign take = d_valid && (ins_cnt_q < CntW'(MAX_ATOMS));
	assign ins = take;
	assign shift = (state_q == Emit) && out_ready && full[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row0 <= '0;
			cfg_q.row1 <= '0;
			cfg_q.row2 <= '0;
			cfg_q.use_types <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				RegRow0: cfg_q.row0 <= cfg_data;
				RegRow1: cfg_q.row1 <= cfg_data;
				RegRow2: cfg_q.row2 <= cfg_data;
				RegTypes: cfg_q.use_types <= cfg_data[0];
				default: ;
			endcase
		end
	end

	lda_dist u_dist (
		.clk(clk), .arst_n(arst_n), .in_valid(acc), .cfg(cfg_q),
		.atom_type(atom_type), .frac_x(frac_x), .frac_y(frac_y), .frac_z(frac_z),
		.in_last(last), .out_valid(d_valid), .out_key(d_key), .out_last(d_last)
	);

	assign full[0] = 1'b1;
	assign gt[0] = 1'b0;
	assign key[0] = '0;
	assign idx[0] = '0;
	assign key[MAX_ATOMS+1] = '0;
	assign idx[MAX_ATOMS+1] = '0;

	for (genvar c = 1; c <= MAX_ATOMS; c++) begin : g_cell
		logic nf;
		if (c == MAX_ATOMS) begin : g_end
			assign nf = 1'b0;
		end else begin : g_mid
			assign nf = full[c+1];
		end
		lda_cell #(.IdxW(IdxW)) u_cell (
			.clk(clk), .arst_n(arst_n), .ins(ins), .shift(shift),
			.new_key(d_key), .new_idx(next_idx_q),
			.prev_full(full[c-1]), .prev_gt(gt[c-1]),
			.prev_key(key[c-1]), .prev_idx(idx[c-1]),
			.next_key(key[c+1]), .next_idx(idx[c+1]), .next_full(nf),
			.full(full[c]), .gt(gt[c]), .key(key[c]), .idx(idx[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Load;
			ins_cnt_q <= '0;
			emit_cnt_q <= '0;
			next_idx_q <= '0;
		end else begin
			case (state_q)
				Load: begin
					if (acc && last)
						state_q <= Drain;
				end
				Drain: begin
					if (d_valid && d_last) begin
						state_q <= Emit;
						emit_cnt_q <= take ? ins_cnt_q + CntW'(1) : ins_cnt_q;
					end
				end
				Emit: begin
					if (shift) begin
						emit_cnt_q <= emit_cnt_q - CntW'(1);
						if (emit_cnt_q == CntW'(1)) begin
							state_q <= Load;
							ins_cnt_q <= '0;
							next_idx_q <= '0;
						end
					end
				end
				default: state_q <= Load;
			endcase
			if (take) begin
				ins_cnt_q <= ins_cnt_q + CntW'(1);
				next_idx_q <= next_idx_q + IdxW'(1);
			end
		end
	end

	assign out_valid = (state_q == Emit) && full[1];
	assign source_index = 6'(idx[1]);
	assign type_out = key[1][KeyW-1 -: TypeW];
	assign distance_sq = key[1][DistW-1:0];
	assign last_out = (emit_cnt_q == CntW'(1));
endmodule
`default_nettype wire

// ===== tb/lattice_distance_argsort_tb.sv =====
// Testbench for the lattice distance argsort block: directed table, random sets, scoreboard.
`timescale 1ns / 100ps
module lattice_distance_argsort_tb;
	import lda_pkg::*;

	typedef struct {
		logic [5:0]  idx;
		logic [7:0]  typ;
		logic [47:0] dsq;
		logic        lst;
	} rank_t;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  reg_idx;
		logic [62:0] data;
		logic [7:0]  typ;
		logic [31:0] x, y, z;
		bit          lst;
		bit          typed;
		logic [47:0] dsq;
	} stim_t;

	localparam int WatchLimit = 3000;
	localparam logic [62:0] RowNeg = {3{21'h100000}};
	localparam logic [62:0] RowPos = {3{21'h0FFFFF}};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [62:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  atom_type;
	logic [31:0] frac_x, frac_y, frac_z;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  source_index;
	logic [7:0]  type_out;
	logic [47:0] distance_sq;
	logic        last_out;

	lattice_distance_argsort dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [62:0] lat_rows [3];
	logic        types_on;
	key_t        atom_keys [64];
	int          stored;
	rank_t       ranks_due [$];
	bit          typed_next;
	rank_t       typed_rank;
	int          errors;
	int          idle_cycles;
	bit          hold_req;
	stim_t       table_rows [$];

	function automatic longint offset_of(logic [31:0] raw);
		logic [23:0] f;
		f = raw[23:0];
		if (f > 24'h800000)
			return longint'(f) - 64'sh1000000;
		if (f == 24'h800000)
			return raw[31] ? 64'sh800000 : -64'sh800000;
		return longint'(f);
	endfunction

	function automatic logic [47:0] lattice_dist(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		longint off [3];
		longint c;
		longint unsigned m, sum;
		logic [20:0] ent;
		off[0] = offset_of(x);
		off[1] = offset_of(y);
		off[2] = offset_of(z);
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			c = 0;
			for (int j = 0; j < 3; j++) begin
				ent = lat_rows[i][21*j +: 21];
				c += longint'($signed(ent)) * off[j];
			end
			m = (c < 0) ? longint'(-c) : longint'(c);
			m = (m + 64'd131072) >> 18;
			sum += m * m;
		end
		return (sum > 64'hFFFFFFFFFFFF) ? 48'hFFFFFFFFFFFF : sum[47:0];
	endfunction

	task automatic sort_and_queue();
		int order [64];
		int j;
		for (int i = 0; i < stored; i++) begin
			j = i;
			while (j > 0 && atom_keys[order[j-1]] > atom_keys[i]) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		for (int i = 0; i < stored; i++)
			ranks_due.push_back('{order[i][5:0], atom_keys[order[i]][55:48],
				atom_keys[order[i]][47:0], i == stored - 1});
		stored = 0;
	endtask

	always @(negedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (stored < 64) begin
				atom_keys[stored] = {types_on ? atom_type : 8'd0,
					lattice_dist(frac_x, frac_y, frac_z)};
				stored++;
			end
			if (last) begin
				if (typed_next) begin
					ranks_due.push_back(typed_rank);
					stored = 0;
					typed_next = 0;
				end else begin
					sort_and_queue();
				end
			end
		end
	end

	always @(negedge clk) begin
		rank_t want;
		if (arst_n && out_valid && out_ready) begin
			if (ranks_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: index %0d type %0d dist %0h",
						source_index, type_out, distance_sq);
			end else begin
				want = ranks_due.pop_front();
				if (want.idx !== source_index || want.typ !== type_out ||
						want.dsq !== distance_sq || want.lst !== last_out) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected idx %0d type %0d dist %0h last %0d,",
							want.idx, want.typ, want.dsq, want.lst,
							" got idx %0d type %0d dist %0h last %0d",
							source_index, type_out, distance_sq, last_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	int  hold_left = 0;
	bit  hold_used = 0;
	int  mode_left = 0;
	bit  always_ready = 0;
	always @(posedge clk) begin
		if (hold_req && !hold_used) begin
			hold_used = 1;
			hold_left = 400;
		end
		if (mode_left == 0) begin
			mode_left = $urandom_range(20, 120);
			always_ready = $urandom_range(0, 2) == 0;
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= always_ready || ($urandom_range(0, 9) < 7);
		end
	end

	int burst_left = 0;
	bit no_gaps = 0;

	task automatic send_atom(logic [7:0] t, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			bit l);
		bit acc;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (!no_gaps) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		atom_type <= t;
		frac_x <= x;
		frac_y <= y;
		frac_z <= z;
		last <= l;
		do begin
			@(negedge clk);
			acc = in_valid && in_ready;
			@(posedge clk);
		end while (!acc);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (ranks_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [62:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == RegTypes)
			types_on = data[0];
		else
			lat_rows[idx] = data;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_atom(logic [7:0] t, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			bit l, bit typed = 0, logic [47:0] d = 0);
		table_rows.push_back('{0, RegRow0, '0, t, x, y, z, l, typed, d});
	endtask

	task automatic add_cfg(logic [1:0] idx, logic [62:0] data);
		table_rows.push_back('{1, idx, data, 0, 0, 0, 0, 0, 0, 0});
	endtask

	function automatic logic [62:0] random_row();
		logic [62:0] r;
		case ($urandom_range(0, 3))
			0: r = 63'({$urandom, $urandom});
			default: begin
				for (int j = 0; j < 3; j++)
					r[21*j +: 21] = 21'($signed($urandom_range(0, 16383)) - 8192);
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] random_coord();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 7))
			0: v[23:0] = 24'h800000;
			1: v[23:0] = 24'h800001;
			2: v[23:0] = 24'h7FFFFF;
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		int sent;
		int n;
		logic [7:0] t;
		logic [31:0] x, y, z;
		bit big_done;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= RegRow0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		atom_type <= '0;
		frac_x <= '0;
		frac_y <= '0;
		frac_z <= '0;
		last <= 1'b0;
		out_ready <= 1'b0;
		lat_rows = '{default: '0};
		types_on = 1;
		stored = 0;
		errors = 0;
		idle_cycles = 0;
		typed_next = 0;
		hold_req = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_atom(8'hFF, 32'h0, 32'h0, 32'h0, 1, 1, 48'h0);
		add_atom(8'h00, 32'h7FFFFFFF, 32'h80000000, 32'h80800000, 1, 1, 48'h0);
		add_cfg(RegTypes, 63'd0);
		add_atom(8'hAA, 32'h00800000, 32'h1, 32'hFFFFFFFF, 1, 1, 48'h0);
		add_cfg(RegTypes, 63'd1);
		add_cfg(RegRow0, RowNeg);
		add_cfg(RegRow1, RowNeg);
		add_cfg(RegRow2, RowNeg);
		add_atom(8'h05, 32'h00800000, 32'h00800000, 32'h00800000, 1, 1, 48'hFFFFFFFFFFFF);
		add_cfg(RegRow0, RowPos);
		add_cfg(RegRow1, RowPos);
		add_cfg(RegRow2, RowPos);
		add_atom(8'h55, 32'h80800000, 32'h80800000, 32'h80800000, 1, 1, 48'hFFFFFFFFFFFF);
		add_cfg(RegRow0, 63'd5120);
		add_cfg(RegRow1, 63'd5120 << 21);
		add_cfg(RegRow2, 63'd5120 << 42);
		add_atom(8'h02, 32'h00800001, 32'h0, 32'h0, 0);
		add_atom(8'h01, 32'h007FFFFF, 32'h00FFFFFF, 32'h0, 0);
		add_atom(8'h02, 32'h00800001, 32'h0, 32'h0, 0);
		add_atom(8'h01, 32'h80800000, 32'h00400000, 32'h12345678, 0);
		add_atom(8'h00, 32'hFFFFFFFF, 32'h0, 32'h00800000, 0);
		add_atom(8'h02, 32'h00000000, 32'h0, 32'h0, 1);

		foreach (table_rows[i]) begin
			if (table_rows[i].is_cfg) begin
				drain();
				write_reg(table_rows[i].reg_idx, table_rows[i].data);
			end else begin
				if (table_rows[i].typed) begin
					typed_rank = '{6'd0, types_on ? table_rows[i].typ : 8'd0,
						table_rows[i].dsq, 1'b1};
					typed_next = 1;
				end
				send_atom(table_rows[i].typ, table_rows[i].x, table_rows[i].y,
					table_rows[i].z, table_rows[i].lst);
			end
		end

		sent = 0;
		big_done = 0;
		while (sent < 380) begin
			if ($urandom_range(0, 4) == 0) begin
				drain();
				for (int r = 0; r < 3; r++)
					write_reg(2'(r), random_row());
				write_reg(RegTypes, 63'($urandom_range(0, 1)));
			end
			no_gaps = $urandom_range(0, 3) == 0;
			if (!big_done && sent > 60) begin
				n = 66;
				big_done = 1;
				hold_req = 1;
			end else if ($urandom_range(0, 15) == 0) begin
				n = 64;
			end else begin
				n = $urandom_range(1, 12);
			end
			for (int k = 0; k < n; k++) begin
				if (k == 0 || $urandom_range(0, 4) != 0) begin
					t = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
					x = random_coord();
					y = random_coord();
					z = random_coord();
				end
				send_atom(t, x, y, z, k == n - 1);
				sent++;
			end
		end

		drain();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== lattice_distance_argsort.f =====
rtl/lda_pkg.sv
rtl/lda_dist.sv
rtl/lda_cell.sv
rtl/lattice_distance_argsort.sv
tb/lattice_distance_argsort_tb.sv
